// File: hw/rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Types, constants and helpers of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_CHARS   = 4;
  localparam int MAX_CHARS   = 4;
  localparam int CHAR_W      = 16;
  localparam int KEY_W       = MAX_CHARS * CHAR_W;
  localparam int VALUE_W     = 16;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SIZE_W      = 7;
  localparam int SUM_W       = CHAR_W + $clog2(MAX_CHARS);
  localparam int HCNT_W      = $clog2(SUM_W);
  localparam int IN_W        = 88;
  localparam int OUT_W       = 32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_DELETED  = 2'd2
  } mark_t;

  typedef struct packed {
    mark_t              mark;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESP
  } state_t;

  function automatic logic [KEY_W-1:0] key_mask();
    logic [KEY_W-1:0] m;
    m = '0;
    for (int c = 0; c < MAX_CHARS; c++) begin
      if (c < KEY_CHARS) begin
        m[c*CHAR_W +: CHAR_W] = '1;
      end
    end
    return m;
  endfunction

  function automatic logic [SUM_W-1:0] char_sum(input logic [KEY_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int c = 0; c < MAX_CHARS; c++) begin
      s = s + SUM_W'(k[c*CHAR_W +: CHAR_W]);
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing key to record table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// sequence: accept, home-slot remainder (one bit a cycle through a
//   shared compare/subtract), probing of up to size slots (one slot memory
//   read a cycle), then the result; probing is skipped when the request ends early
// throughput: one item at a time, ready only when idle; a finished result may
//   wait in the output register while the next item is taken
// reset: synchronous; per-slot valid bits clear at once, size returns to 64
module linear_probe_hash_table_unit
  import lpht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // req_type[1:0], key[65:2], value_index[81:66], zero fill
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status[1:0], found_value[17:2], probe_count[24:18], table_empty[25], zero fill
  output logic [OUT_W-1:0]  m_axis_tdata
);

  state_t state, state_next;

  logic [SIZE_W-1:0]  table_size_in_use;
  logic [SIZE_W-1:0]  size;
  logic [CNT_W-1:0]   occupied_count;
  logic [TABLE_DEPTH-1:0] slot_vld;

  logic [REQ_W-1:0]   req_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SIZE_W-1:0]  rem;
  logic [HCNT_W-1:0]  hcnt;

  logic [IDX_W-1:0]   issue_idx;
  logic [CNT_W-1:0]   issue_cnt;
  logic               chk_valid;
  logic [IDX_W-1:0]   chk_idx;
  logic [CNT_W-1:0]   chk_cnt;
  slot_t              rd_row;

  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_found;
  logic [CNT_W-1:0]    res_probe;

  slot_t mem [TABLE_DEPTH];

  // combinational control
  logic               in_xfer;
  logic               hash_last;
  logic               early_done;
  logic [STATUS_W-1:0] early_status;
  logic [SIZE_W:0]    rem_trial;
  logic [SIZE_W-1:0]  rem_step;
  logic               issue;
  mark_t              chk_mark;
  logic               chk_hit;
  logic               chk_last;
  logic               stop;
  logic [STATUS_W-1:0] stop_status;
  logic [VALUE_W-1:0]  stop_found;
  logic [CNT_W-1:0]    stop_probe;
  logic               mem_we;
  slot_t              wr_row;
  logic               occ_inc;
  logic               occ_dec;
  logic               out_load;

  // effective size clamped to 1..depth
  always_comb begin
    if (table_size_in_use == '0) begin
      size = SIZE_W'(1);
    end else if (table_size_in_use > SIZE_W'(TABLE_DEPTH)) begin
      size = SIZE_W'(TABLE_DEPTH);
    end else begin
      size = table_size_in_use;
    end
  end

  // shared remainder step
  always_comb begin
    rem_trial = {rem, sum_q[SUM_W-1]};
    if (rem_trial >= {1'b0, size}) begin
      rem_step = SIZE_W'(rem_trial - {1'b0, size});
    end else begin
      rem_step = rem_trial[SIZE_W-1:0];
    end
  end

  assign hash_last = (hcnt == HCNT_W'(SUM_W - 1));

  always_comb begin
    early_done   = 1'b0;
    early_status = ST_NOT_FOUND;
    if (req_q == REQ_INSERT) begin
      if (CNT_W'(occupied_count) >= CNT_W'(size)) begin
        early_done   = 1'b1;
        early_status = ST_FULL;
      end
    end else if (req_q != REQ_FIND && req_q != REQ_REMOVE) begin
      early_done = 1'b1;
    end
  end

  // probe evaluation
  always_comb begin
    chk_mark    = slot_vld[chk_idx] ? rd_row.mark : MARK_EMPTY;
    chk_hit     = (chk_mark == MARK_OCCUPIED) && (rd_row.key == key_q);
    chk_last    = (chk_cnt == CNT_W'(size));
    stop        = 1'b0;
    stop_status = ST_NOT_FOUND;
    stop_found  = '0;
    stop_probe  = '0;
    mem_we      = 1'b0;
    wr_row      = rd_row;
    occ_inc     = 1'b0;
    occ_dec     = 1'b0;
    if (state == S_PROBE && chk_valid) begin
      unique case (req_q)
        REQ_INSERT: begin
          if (chk_mark == MARK_EMPTY) begin
            stop        = 1'b1;
            stop_status = ST_OK;
            mem_we      = 1'b1;
            wr_row.mark = MARK_OCCUPIED;
            wr_row.key  = key_q;
            wr_row.value = value_q;
            occ_inc     = 1'b1;
          end else if (chk_hit) begin
            stop        = 1'b1;
            stop_status = ST_DUPLICATE;
          end else if (chk_last) begin
            stop        = 1'b1;
            stop_status = ST_FULL;
          end
        end
        REQ_FIND: begin
          if (chk_hit) begin
            stop        = 1'b1;
            stop_status = ST_OK;
            stop_found  = rd_row.value;
            stop_probe  = chk_cnt;
          end else if (chk_mark == MARK_EMPTY || chk_last) begin
            stop = 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (chk_hit) begin
            stop        = 1'b1;
            stop_status = ST_OK;
            mem_we      = 1'b1;
            wr_row.mark = MARK_DELETED;
            occ_dec     = (occupied_count != '0);
          end else if (chk_last) begin
            stop = 1'b1;
          end
        end
        default: begin
          stop = 1'b1;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_last) begin
          state_next = early_done ? S_RESP : S_PROBE;
        end
      end
      S_PROBE: begin
        if (stop) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    issue         = (state == S_PROBE) && (issue_cnt < CNT_W'(size));
    out_load      = (state == S_RESP) && (!m_axis_tvalid || m_axis_tready);
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      table_size_in_use <= SIZE_RESET;
      occupied_count    <= '0;
      slot_vld          <= '0;
      chk_valid         <= 1'b0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        table_size_in_use <= cfg_wr_data;
      end
      if (occ_inc) begin
        occupied_count <= occupied_count + CNT_W'(1);
      end else if (occ_dec) begin
        occupied_count <= occupied_count - CNT_W'(1);
      end
      if (mem_we) begin
        slot_vld[chk_idx] <= 1'b1;
      end
      chk_valid <= issue && !stop;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_q   <= s_axis_tdata[1:0];
      key_q   <= s_axis_tdata[2 +: KEY_W] & key_mask();
      value_q <= s_axis_tdata[2 + KEY_W +: VALUE_W];
      sum_q   <= char_sum(s_axis_tdata[2 +: KEY_W] & key_mask());
      rem     <= '0;
      hcnt    <= '0;
    end
    if (state == S_HASH) begin
      rem   <= rem_step;
      sum_q <= {sum_q[SUM_W-2:0], 1'b0};
      hcnt  <= hcnt + HCNT_W'(1);
      if (hash_last) begin
        issue_idx  <= rem_step[IDX_W-1:0];
        issue_cnt  <= '0;
        res_status <= early_status;
        res_found  <= '0;
        res_probe  <= '0;
      end
    end
    if (issue) begin
      rd_row    <= mem[issue_idx];
      chk_idx   <= issue_idx;
      chk_cnt   <= issue_cnt + CNT_W'(1);
      issue_cnt <= issue_cnt + CNT_W'(1);
      if ((CNT_W'(issue_idx) + CNT_W'(1)) == CNT_W'(size)) begin
        issue_idx <= '0;
      end else begin
        issue_idx <= issue_idx + IDX_W'(1);
      end
    end
    if (stop) begin
      res_status <= stop_status;
      res_found  <= stop_found;
      res_probe  <= stop_probe;
    end
    if (mem_we) begin
      mem[chk_idx] <= wr_row;
    end
    if (out_load) begin
      m_axis_tdata <= {6'd0, (occupied_count == '0), res_probe, res_found, res_status};
    end
  end

endmodule
